[hw/rtl/hcs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared types, codes and constants of the hydraulic cycle sequencer.
// ----------------------------------------------------------------------------
package hcs_pkg;

  localparam int MS_W   = 20;
  localparam int PSI_W  = 16;
  localparam int CIDX_W = 3;

  localparam logic [MS_W-1:0] MS_MAX = {MS_W{1'b1}};

  // pins watched by the new-press check, and the limit switch pins
  localparam logic [3:0] PIN_WATCH_LO = 4'd2;
  localparam logic [3:0] PIN_WATCH_HI = 4'd5;
  localparam logic [3:0] PIN_EXT_LIM  = 4'd6;
  localparam logic [3:0] PIN_RET_LIM  = 4'd7;

  // register indexes
  localparam logic [CIDX_W-1:0] CFG_LIMIT_STABLE = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_START_STABLE = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_TIMEOUT      = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_EXT_PSI      = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_RET_PSI      = 3'd4;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_PIN       = 3'd1,
    OP_MAN_EXT   = 3'd2,
    OP_MAN_RET   = 3'd3,
    OP_MAN_STOP  = 3'd4,
    OP_RESET     = 3'd5,
    OP_CLR_LOCK  = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_DEB  = 3'd1,
    ST_S1   = 3'd2,
    ST_S1W  = 3'd3,
    ST_S2   = 3'd4,
    ST_S2W  = 3'd5,
    ST_MEXT = 3'd6,
    ST_MRET = 3'd7
  } seq_st_t;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_CHANGE  = 2'd1,
    EV_ABORT   = 2'd2,
    EV_TIMEOUT = 2'd3
  } ev_t;

  localparam logic [1:0] STAGE_NONE = 2'd0;
  localparam logic [1:0] STAGE_EXT  = 2'd1;
  localparam logic [1:0] STAGE_RET  = 2'd2;

  typedef struct packed {
    logic [MS_W-1:0]  limit_stable_ms;
    logic [MS_W-1:0]  start_stable_ms;
    logic [MS_W-1:0]  state_timeout_ms;
    logic [PSI_W-1:0] extend_pressure_limit;
    logic [PSI_W-1:0] retract_pressure_limit;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [3:0]       pin;
    logic             pin_level;
    logic             start_button;
    logic             held_at_start;
    logic             extend_limit;
    logic             retract_limit;
    logic             pressure_ready;
    logic [PSI_W-1:0] pressure;
  } item_t;

  typedef struct packed {
    logic       extend_relay;
    logic       retract_relay;
    logic [2:0] seq_state;
    logic [1:0] stage;
    logic       handled;
    logic [1:0] event_res;
    logic       locked_out;
    logic       pressure_limit_hit;
    logic       timeout_error;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/hcs_cmd_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcs_cmd_if
// Input item channel: valid/ready with the event fields.
// ----------------------------------------------------------------------------
interface hcs_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [3:0]  pin;
  logic        pin_level;
  logic        start_button;
  logic        held_at_start;
  logic        extend_limit;
  logic        retract_limit;
  logic        pressure_ready;
  logic [15:0] pressure;

  modport source (
    output valid, op, pin, pin_level, start_button, held_at_start,
           extend_limit, retract_limit, pressure_ready, pressure,
    input  ready
  );
  modport sink (
    input  valid, op, pin, pin_level, start_button, held_at_start,
           extend_limit, retract_limit, pressure_ready, pressure,
    output ready
  );
endinterface
`default_nettype wire

[hw/rtl/hcs_res_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcs_res_if
// Result channel: valid/ready with relay drives, state and event flags.
// ----------------------------------------------------------------------------
interface hcs_res_if;
  logic       valid;
  logic       ready;
  logic       extend_relay;
  logic       retract_relay;
  logic [2:0] seq_state;
  logic [1:0] stage;
  logic       handled;
  logic [1:0] event_res;
  logic       locked_out;
  logic       pressure_limit_hit;
  logic       timeout_error;

  modport source (
    output valid, extend_relay, retract_relay, seq_state, stage, handled,
           event_res, locked_out, pressure_limit_hit, timeout_error,
    input  ready
  );
  modport sink (
    input  valid, extend_relay, retract_relay, seq_state, stage, handled,
           event_res, locked_out, pressure_limit_hit, timeout_error,
    output ready
  );
endinterface
`default_nettype wire

[hw/rtl/hcs_cfg_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcs_cfg_if
// Register write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
interface hcs_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [19:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/hcs_cfg_regs.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcs_cfg_regs
// Configuration register file, written one beat at a time.
// ----------------------------------------------------------------------------
module hcs_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  hcs_cfg_if.sink       cfg,
  output hcs_pkg::cfg_t regs
);
  import hcs_pkg::*;

  // writes are always taken
  assign cfg.ready = 1'b1;

  // register decode, out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.limit_stable_ms        <= MS_W'(100);
      regs.start_stable_ms        <= MS_W'(100);
      regs.state_timeout_ms       <= MS_W'(30000);
      regs.extend_pressure_limit  <= PSI_W'(25000);
      regs.retract_pressure_limit <= PSI_W'(25000);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_LIMIT_STABLE: regs.limit_stable_ms        <= cfg.data;
        CFG_START_STABLE: regs.start_stable_ms        <= cfg.data;
        CFG_TIMEOUT:      regs.state_timeout_ms       <= cfg.data;
        CFG_EXT_PSI:      regs.extend_pressure_limit  <= cfg.data[PSI_W-1:0];
        CFG_RET_PSI:      regs.retract_pressure_limit <= cfg.data[PSI_W-1:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/hcs_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hcs_core
// Sequencer state and its single-pass update for one registered item.
// ----------------------------------------------------------------------------
module hcs_core (
  input  logic             clk,
  input  logic             rst,
  input  hcs_pkg::cfg_t    regs,
  input  hcs_pkg::item_t   item,
  input  logic             commit,
  output hcs_pkg::result_t result
);
  import hcs_pkg::*;

  typedef struct packed {
    seq_st_t         st;
    logic [MS_W-1:0] state_elapsed;
    logic            limit_on;
    logic [MS_W-1:0] limit_elapsed;
    logic            release_allowed;
    logic            lockout;
    logic            rly_ext;
    logic            rly_ret;
  } core_t;

  core_t cur;
  core_t nxt;
  logic  aborted;
  logic  timed_out;
  logic  handled;
  logic  phit;
  logic  ext_p;
  logic  ret_p;
  logic  watch_rise;
  logic  in_s1;
  logic  in_auto;
  logic  ev_change;

  function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] v);
    return (v == MS_MAX) ? v : v + MS_W'(1);
  endfunction

  // state change clears the state time and the limit timer
  function automatic core_t go_state(input core_t s, input seq_st_t n);
    core_t r;
    r = s;
    if (s.st != n) begin
      r.st            = n;
      r.state_elapsed = '0;
      r.limit_on      = 1'b0;
      r.limit_elapsed = '0;
    end
    return r;
  endfunction

  function automatic core_t abort_state(input core_t s, input logic tmo);
    core_t r;
    r                 = s;
    r.rly_ext         = 1'b0;
    r.rly_ret         = 1'b0;
    r                 = go_state(r, ST_IDLE);
    r.release_allowed = 1'b0;
    if (tmo) r.lockout = 1'b1;
    return r;
  endfunction

  // pressure threshold compares
  assign ext_p = item.pressure_ready && (item.pressure >= regs.extend_pressure_limit);
  assign ret_p = item.pressure_ready && (item.pressure >= regs.retract_pressure_limit);

  assign watch_rise = cur.release_allowed && (item.pin >= PIN_WATCH_LO) &&
                      (item.pin <= PIN_WATCH_HI) && item.pin_level && !item.held_at_start;
  assign in_s1   = (cur.st == ST_S1) || (cur.st == ST_S1W);
  assign in_auto = in_s1 || (cur.st == ST_S2) || (cur.st == ST_S2W);

  // next state for the current item
  always_comb begin
    nxt       = cur;
    aborted   = 1'b0;
    timed_out = 1'b0;
    handled   = 1'b0;
    phit      = 1'b0;
    case (item.op)
      OP_TICK: begin
        nxt.state_elapsed = sat_inc(cur.state_elapsed);
        if (cur.limit_on) nxt.limit_elapsed = sat_inc(cur.limit_elapsed);
        if (cur.st != ST_IDLE && nxt.state_elapsed > regs.state_timeout_ms) begin
          nxt       = abort_state(nxt, 1'b1);
          aborted   = 1'b1;
          timed_out = 1'b1;
        end else begin
          case (cur.st)
            ST_DEB: begin
              if (nxt.state_elapsed >= regs.start_stable_ms) begin
                nxt                 = go_state(nxt, ST_S1);
                nxt.rly_ext         = 1'b1;
                nxt.rly_ret         = 1'b0;
                nxt.release_allowed = 1'b1;
              end
            end
            ST_MEXT: begin
              if (item.extend_limit || ext_p) begin
                nxt.rly_ext = 1'b0;
                nxt         = go_state(nxt, ST_IDLE);
              end
            end
            ST_MRET: begin
              if (item.retract_limit || ret_p) begin
                nxt.rly_ret = 1'b0;
                nxt         = go_state(nxt, ST_IDLE);
              end
            end
            ST_S1, ST_S1W, ST_S2, ST_S2W: begin
              phit = in_s1 ? ext_p : ret_p;
              if (!((in_s1 ? item.extend_limit : item.retract_limit) || phit)) begin
                nxt.limit_on      = 1'b0;
                nxt.limit_elapsed = '0;
              end else if (!cur.limit_on) begin
                nxt.limit_on      = 1'b1;
                nxt.limit_elapsed = '0;
              end else if (nxt.limit_elapsed >= regs.limit_stable_ms) begin
                if (in_s1) begin
                  nxt         = go_state(nxt, ST_S2);
                  nxt.rly_ext = 1'b0;
                  nxt.rly_ret = 1'b1;
                end else begin
                  nxt.rly_ret         = 1'b0;
                  nxt                 = go_state(nxt, ST_IDLE);
                  nxt.release_allowed = 1'b0;
                end
                nxt.limit_on      = 1'b0;
                nxt.limit_elapsed = '0;
              end
            end
            default: ;
          endcase
        end
      end
      OP_PIN: begin
        handled = 1'b1;
        if (cur.st == ST_IDLE) begin
          if (cur.lockout || !item.start_button) handled = 1'b0;
          else nxt = go_state(cur, ST_DEB);
        end else if (cur.st == ST_DEB) begin
          if (!item.start_button) begin
            nxt     = abort_state(cur, 1'b0);
            aborted = 1'b1;
          end
        end else if (in_auto) begin
          if (watch_rise || (in_s1 && !cur.release_allowed && !item.start_button)) begin
            nxt     = abort_state(cur, 1'b0);
            aborted = 1'b1;
          end else if (item.pin == (in_s1 ? PIN_EXT_LIM : PIN_RET_LIM) && item.pin_level) begin
            nxt.limit_on      = 1'b1;
            nxt.limit_elapsed = '0;
            // leaving a moving stage stops the timer again
            if (cur.st == ST_S1)      nxt = go_state(nxt, ST_S1W);
            else if (cur.st == ST_S2) nxt = go_state(nxt, ST_S2W);
          end
        end
      end
      OP_MAN_EXT: begin
        if (cur.st == ST_IDLE && !cur.lockout && !item.extend_limit && !ext_p) begin
          nxt         = go_state(cur, ST_MEXT);
          nxt.rly_ext = 1'b1;
          handled     = 1'b1;
        end
      end
      OP_MAN_RET: begin
        if (cur.st == ST_IDLE && !cur.lockout && !item.retract_limit && !ret_p) begin
          nxt         = go_state(cur, ST_MRET);
          nxt.rly_ret = 1'b1;
          handled     = 1'b1;
        end
      end
      OP_MAN_STOP: begin
        if (cur.st == ST_MEXT || cur.st == ST_MRET) begin
          if (cur.st == ST_MEXT) nxt.rly_ext = 1'b0;
          else nxt.rly_ret = 1'b0;
          nxt     = go_state(nxt, ST_IDLE);
          handled = 1'b1;
        end
      end
      OP_RESET: begin
        nxt     = abort_state(cur, 1'b0);
        aborted = 1'b1;
      end
      OP_CLR_LOCK: nxt.lockout = 1'b0;
      default: ;
    endcase
  end

  // result fields from the updated state
  assign ev_change = (nxt.st != cur.st);

  always_comb begin
    result.extend_relay       = nxt.rly_ext;
    result.retract_relay      = nxt.rly_ret;
    result.seq_state          = nxt.st;
    result.handled            = handled;
    result.locked_out         = nxt.lockout;
    result.pressure_limit_hit = phit;
    result.timeout_error      = timed_out;
    if (timed_out)      result.event_res = EV_TIMEOUT;
    else if (aborted)   result.event_res = EV_ABORT;
    else if (ev_change) result.event_res = EV_CHANGE;
    else                result.event_res = EV_NONE;
    if (nxt.st == ST_S1 || nxt.st == ST_S1W)      result.stage = STAGE_EXT;
    else if (nxt.st == ST_S2 || nxt.st == ST_S2W) result.stage = STAGE_RET;
    else                                          result.stage = STAGE_NONE;
  end

  // state register, updated once per committed item
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '{st: ST_IDLE, default: '0};
    end else if (commit) begin
      cur <= nxt;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/hydraulic_cycle_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hydraulic_cycle_sequencer
// Two-stage extend/retract cylinder sequencer with manual moves and lockout.
// ----------------------------------------------------------------------------
// an accepted item is held in the input register, then its result in the result register that drives res
// throughput: one item per cycle while res is not stalled, set by the single-pass state update
// a stalled result holds the input stage; both stages stall together
// reset (rst, synchronous): idle, relays off, no lockout, registers to defaults
// ----------------------------------------------------------------------------
module hydraulic_cycle_sequencer (
  input  logic      clk,
  input  logic      rst,
  hcs_cmd_if.sink   cmd,
  hcs_res_if.source res,
  hcs_cfg_if.sink   cfg
);
  import hcs_pkg::*;

  cfg_t    regs;
  item_t   item_q;
  logic    item_valid;
  result_t res_d;
  result_t res_q;
  logic    res_valid;
  logic    advance;
  logic    commit;

  hcs_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  hcs_core u_core (
    .clk    (clk),
    .rst    (rst),
    .regs   (regs),
    .item   (item_q),
    .commit (commit),
    .result (res_d)
  );

  // pipeline flow control
  assign advance   = !res_valid || res.ready;
  assign commit    = item_valid && advance;
  assign cmd.ready = !item_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      item_q <= '{op: cmd.op, pin: cmd.pin, pin_level: cmd.pin_level,
                  start_button: cmd.start_button, held_at_start: cmd.held_at_start,
                  extend_limit: cmd.extend_limit, retract_limit: cmd.retract_limit,
                  pressure_ready: cmd.pressure_ready, pressure: cmd.pressure};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) res_q <= res_d;
  end

  // result beat
  assign res.valid              = res_valid;
  assign res.extend_relay       = res_q.extend_relay;
  assign res.retract_relay      = res_q.retract_relay;
  assign res.seq_state          = res_q.seq_state;
  assign res.stage              = res_q.stage;
  assign res.handled            = res_q.handled;
  assign res.event_res          = res_q.event_res;
  assign res.locked_out         = res_q.locked_out;
  assign res.pressure_limit_hit = res_q.pressure_limit_hit;
  assign res.timeout_error      = res_q.timeout_error;
endmodule
`default_nettype wire
